FILE: sv/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg: shared definitions for the binary min-heap queue
// Default sizes, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int DEF_HEAP_DEPTH = 64;
  localparam int DEF_COST_BITS  = 32;
  localparam int DEF_NODE_BITS  = 16;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // operation codes carried on s_tuser
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

  // status codes carried on m_tuser
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FIND_MISS = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_CHK,
    ST_PUSH_CMP,
    ST_POP_LOAD,
    ST_POP_CHK,
    ST_POP_SEL,
    ST_POP_CMP,
    ST_FIND_CHK,
    ST_FIND_CMP,
    ST_DONE
  } bmh_state_t;

endpackage

FILE: sv/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue: min-heap priority queue of (cost, node id) entries
//
// Requests arrive on the s_ channel: s_tuser carries the operation (push,
// pop minimum, find by node id), s_tdata the node id and cost. Each request
// gives one response on the m_ channel: m_tuser carries the status, m_tdata
// the popped or found entry, the entry count and the current head entry.
// Requests are handled one at a time; s_tready is high only while the
// sequencer is idle. A push sifts the new entry up from the last slot,
// one level per step; a pop moves the last entry to the root and sifts it
// down one level per step; a find reads and compares one held entry per
// step. A push when full, a pop when empty or when the only entry leaves,
// and an unused kind respond without a sift or scan.
// s_tready returns together with m_tvalid.
// Paced by the registered reads of the one entry store and one comparator.
// The response sits in an output register, so a new request is taken while
// an earlier response waits; a stalled m_tready holds the finished next
// response in the sequencer and then holds s_tready low.
// Reset empties the queue at once; the entry store needs no clearing.
// ----------------------------------------------------------------------------
module binary_min_heap_queue import bmh_pkg::*; #(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int COST_BITS  = DEF_COST_BITS,
  parameter int NODE_BITS  = DEF_NODE_BITS,
  localparam int CW        = $clog2(HEAP_DEPTH + 1),
  localparam int IN_BITS   = NODE_BITS + COST_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 * (NODE_BITS + COST_BITS) + CW + 1,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // node_id, cost
  input  logic [KIND_W-1:0]   s_tuser,   // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,   // result_node, result_cost, entry_count,
                                         // head_valid, head_node, head_cost
  output logic [STATUS_W-1:0] m_tuser    // status
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int EW = NODE_BITS + COST_BITS;

  logic                 res_valid, res_ready, res_head_valid;
  logic [NODE_BITS-1:0] res_node, res_head_node;
  logic [COST_BITS-1:0] res_cost, res_head_cost;
  logic [STATUS_W-1:0]  res_status;
  logic [CW-1:0]        res_count;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  logic [EW-1:0]        wr_data, rd_data_a, rd_data_b;
  logic [OUT_BITS-1:0]  out_pack;

  bmh_seq #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .COST_BITS  (COST_BITS),
    .NODE_BITS  (NODE_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_kind        (s_tuser),
    .in_node        (s_tdata[NODE_BITS-1:0]),
    .in_cost        (s_tdata[IN_BITS-1:NODE_BITS]),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_node       (res_node),
    .res_cost       (res_cost),
    .res_status     (res_status),
    .res_count      (res_count),
    .res_head_valid (res_head_valid),
    .res_head_node  (res_head_node),
    .res_head_cost  (res_head_cost),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .rd_data_a      (rd_data_a),
    .rd_data_b      (rd_data_b)
  );

  bmh_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign out_pack  = {res_head_cost, res_head_node, res_head_valid, res_count,
                      res_cost, res_node};
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      m_tdata <= OUT_W'(out_pack);
      m_tuser <= res_status;
    end
  end

endmodule

FILE: sv/bmh_ram.sv
// ----------------------------------------------------------------------------
// bmh_ram: heap entry store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmh_ram import bmh_pkg::*; #(
  parameter int DEPTH = DEF_HEAP_DEPTH,
  parameter int WIDTH = DEF_NODE_BITS + DEF_COST_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: sv/bmh_seq.sv
// ----------------------------------------------------------------------------
// bmh_seq: heap operation sequencer
// Runs push sift-up, pop sift-down and find scan over the entry store,
// one level or one entry at a time; the sift steps share a single cost comparator.
// ----------------------------------------------------------------------------
module bmh_seq import bmh_pkg::*; #(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int COST_BITS  = DEF_COST_BITS,
  parameter int NODE_BITS  = DEF_NODE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // request side
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [KIND_W-1:0]                 in_kind,
  input  logic [NODE_BITS-1:0]              in_node,
  input  logic [COST_BITS-1:0]              in_cost,
  // result side
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [NODE_BITS-1:0]              res_node,
  output logic [COST_BITS-1:0]              res_cost,
  output logic [STATUS_W-1:0]               res_status,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]   res_count,
  output logic                              res_head_valid,
  output logic [NODE_BITS-1:0]              res_head_node,
  output logic [COST_BITS-1:0]              res_head_cost,
  // entry store
  output logic                              wr_en,
  output logic [$clog2(HEAP_DEPTH)-1:0]     wr_addr,
  output logic [NODE_BITS+COST_BITS-1:0]    wr_data,
  output logic [$clog2(HEAP_DEPTH)-1:0]     rd_addr_a,
  output logic [$clog2(HEAP_DEPTH)-1:0]     rd_addr_b,
  input  logic [NODE_BITS+COST_BITS-1:0]    rd_data_a,
  input  logic [NODE_BITS+COST_BITS-1:0]    rd_data_b
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;

  bmh_state_t state, state_next;

  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        cur, cur_next;
  logic [NODE_BITS-1:0] x_node, x_node_next;
  logic [COST_BITS-1:0] x_cost, x_cost_next;
  logic [NODE_BITS-1:0] chd_node, chd_node_next;
  logic [COST_BITS-1:0] chd_cost, chd_cost_next;
  logic [AW-1:0]        chd_idx, chd_idx_next;
  logic [CW-1:0]        scan, scan_next;
  logic [NODE_BITS-1:0] key, key_next;
  logic [NODE_BITS-1:0] rnode, rnode_next;
  logic [COST_BITS-1:0] rcost, rcost_next;
  logic [STATUS_W-1:0]  status, status_next;
  logic [NODE_BITS-1:0] head_node;
  logic [COST_BITS-1:0] head_cost;

  logic [NODE_BITS-1:0] rda_node, rdb_node;
  logic [COST_BITS-1:0] rda_cost, rdb_cost;
  logic [COST_BITS-1:0] cmp_a, cmp_b;
  logic                 cmp_lt;
  logic [XW-1:0]        lchild, rchild, n_ext;
  logic [AW-1:0]        cur_dec, parent;
  logic [CW-1:0]        last_idx;
  logic                 full, at_leaf, has_right, scan_end;

  assign {rda_node, rda_cost} = rd_data_a;
  assign {rdb_node, rdb_cost} = rd_data_b;

  // child and parent index arithmetic, wide enough not to wrap
  assign lchild    = XW'({cur, 1'b1});
  assign rchild    = lchild + XW'(1);
  assign n_ext     = XW'(count);
  assign at_leaf   = (lchild >= n_ext);
  assign has_right = (rchild < n_ext);
  assign cur_dec   = cur - AW'(1);
  assign parent    = cur_dec >> 1;
  assign last_idx  = count - CW'(1);
  assign full      = (count == CW'(HEAP_DEPTH));
  assign scan_end  = (scan >= count);

  // the one cost comparator, operands picked by step
  always_comb begin
    case (state)
      ST_PUSH_CMP: begin
        cmp_a = x_cost;
        cmp_b = rda_cost;
      end
      ST_POP_SEL: begin
        cmp_a = rdb_cost;
        cmp_b = rda_cost;
      end
      ST_POP_CMP: begin
        cmp_a = chd_cost;
        cmp_b = x_cost;
      end
      default: begin
        cmp_a = x_cost;
        cmp_b = rda_cost;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_PUSH: state_next = full ? ST_DONE : ST_PUSH_CHK;
            KIND_POP: begin
              if (count <= CW'(1)) state_next = ST_DONE;
              else                 state_next = ST_POP_LOAD;
            end
            KIND_FIND: state_next = ST_FIND_CHK;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_PUSH_CHK: state_next = (cur == '0) ? ST_DONE : ST_PUSH_CMP;
      ST_PUSH_CMP: state_next = cmp_lt ? ST_PUSH_CHK : ST_DONE;
      ST_POP_LOAD: state_next = ST_POP_CHK;
      ST_POP_CHK:  state_next = at_leaf ? ST_DONE : ST_POP_SEL;
      ST_POP_SEL:  state_next = ST_POP_CMP;
      ST_POP_CMP:  state_next = cmp_lt ? ST_POP_CHK : ST_DONE;
      ST_FIND_CHK: state_next = scan_end ? ST_DONE : ST_FIND_CMP;
      ST_FIND_CMP: state_next = (rda_node == key) ? ST_DONE : ST_FIND_CHK;
      ST_DONE:     state_next = res_ready ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath and store access
  always_comb begin
    count_next    = count;
    cur_next      = cur;
    x_node_next   = x_node;
    x_cost_next   = x_cost;
    chd_node_next = chd_node;
    chd_cost_next = chd_cost;
    chd_idx_next  = chd_idx;
    scan_next     = scan;
    key_next      = key;
    rnode_next    = rnode;
    rcost_next    = rcost;
    status_next   = status;
    wr_en         = 1'b0;
    wr_addr       = cur;
    wr_data       = {x_node, x_cost};
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    case (state)
      ST_IDLE: begin
        rnode_next  = '0;
        rcost_next  = '0;
        status_next = STATUS_OK;
        x_node_next = in_node;
        x_cost_next = in_cost;
        key_next    = in_node;
        scan_next   = '0;
        cur_next    = '0;
        rd_addr_a   = last_idx[AW-1:0];
        if (in_valid) begin
          case (in_kind)
            KIND_PUSH: begin
              if (full) begin
                status_next = STATUS_PUSH_FULL;
              end else begin
                cur_next   = count[AW-1:0];
                count_next = count + CW'(1);
              end
            end
            KIND_POP: begin
              if (count == '0) begin
                status_next = STATUS_POP_EMPTY;
              end else begin
                rnode_next = head_node;
                rcost_next = head_cost;
                count_next = last_idx;
              end
            end
            KIND_FIND: status_next = STATUS_FIND_MISS;
            default:   status_next = STATUS_OK;
          endcase
        end
      end
      ST_PUSH_CHK: begin
        rd_addr_a = parent;
        if (cur == '0) begin
          wr_en = 1'b1;
        end
      end
      ST_PUSH_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          wr_data  = rd_data_a;
          cur_next = parent;
        end
      end
      ST_POP_LOAD: begin
        x_node_next = rda_node;
        x_cost_next = rda_cost;
      end
      ST_POP_CHK: begin
        rd_addr_a = lchild[AW-1:0];
        rd_addr_b = rchild[AW-1:0];
        if (at_leaf) begin
          wr_en = 1'b1;
        end
      end
      ST_POP_SEL: begin
        // right child only when strictly cheaper
        if (has_right && cmp_lt) begin
          chd_node_next = rdb_node;
          chd_cost_next = rdb_cost;
          chd_idx_next  = rchild[AW-1:0];
        end else begin
          chd_node_next = rda_node;
          chd_cost_next = rda_cost;
          chd_idx_next  = lchild[AW-1:0];
        end
      end
      ST_POP_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data  = {chd_node, chd_cost};
          cur_next = chd_idx;
        end
      end
      ST_FIND_CHK: begin
        rd_addr_a = scan[AW-1:0];
      end
      ST_FIND_CMP: begin
        if (rda_node == key) begin
          rnode_next  = rda_node;
          rcost_next  = rda_cost;
          status_next = STATUS_OK;
        end else begin
          scan_next = scan + CW'(1);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cur      <= cur_next;
    x_node   <= x_node_next;
    x_cost   <= x_cost_next;
    chd_node <= chd_node_next;
    chd_cost <= chd_cost_next;
    chd_idx  <= chd_idx_next;
    scan     <= scan_next;
    key      <= key_next;
    rnode    <= rnode_next;
    rcost    <= rcost_next;
    status   <= status_next;
    // shadow of the root entry, follows every write to slot zero
    if (wr_en && wr_addr == '0) begin
      {head_node, head_cost} <= wr_data;
    end
  end

  assign in_ready       = (state == ST_IDLE);
  assign res_valid      = (state == ST_DONE);
  assign res_node       = rnode;
  assign res_cost       = rcost;
  assign res_status     = status;
  assign res_count      = count;
  assign res_head_valid = (count != '0);
  assign res_head_node  = res_head_valid ? head_node : '0;
  assign res_head_cost  = res_head_valid ? head_cost : '0;

endmodule

FILE: sv/bmh_checker.sv
// ----------------------------------------------------------------------------
// bmh_checker: port-level checks for the heap queue
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module bmh_checker import bmh_pkg::*; #(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int COST_BITS  = DEF_COST_BITS,
  parameter int NODE_BITS  = DEF_NODE_BITS,
  localparam int CW        = $clog2(HEAP_DEPTH + 1),
  localparam int IN_W      = ((NODE_BITS + COST_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((2 * (NODE_BITS + COST_BITS) + CW + 1 + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [IN_W-1:0]     s_tdata,
  input logic [KIND_W-1:0]   s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_W-1:0]    m_tdata,
  input logic [STATUS_W-1:0] m_tuser
);

  localparam int CNT_LO = NODE_BITS + COST_BITS;
  localparam int HV_BIT = CNT_LO + CW;

  logic [CW-1:0] cnt;
  logic          hv;

  assign cnt = m_tdata[HV_BIT-1:CNT_LO];
  assign hv  = m_tdata[HV_BIT];

  // no response may be pending straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("response valid after reset");

  // a stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled response changed");

  // one request at a time: busy right after taking one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // head flag agrees with the count, count within capacity
  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hv == (cnt != '0)) && (cnt <= CW'(HEAP_DEPTH)))
    else $error("head flag or count inconsistent");

  // pop on empty only reported with an empty queue
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_POP_EMPTY) |-> (cnt == '0))
    else $error("pop-empty status with entries held");

endmodule

bind binary_min_heap_queue bmh_checker #(
  .HEAP_DEPTH (HEAP_DEPTH),
  .COST_BITS  (COST_BITS),
  .NODE_BITS  (NODE_BITS)
) u_bmh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
